@@ rtl/core/gblur_pkg.sv @@
// ----------------------------------------------------------------------------
// gblur_pkg
// Shared widths, codes, types and arithmetic of the 3x3 binomial blur.
// ----------------------------------------------------------------------------
`default_nettype none

package gblur_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned FW_W  = 9;
    localparam int unsigned FH_W  = 10;
    localparam int unsigned VS_W  = 10;
    localparam int unsigned SUM_W = 12;

    localparam int unsigned MAX_WIDTH_DEF = 256;

    localparam int unsigned CFG_AW = 1;
    localparam int unsigned CFG_DW = 10;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 9'd160;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 10'd31;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam int unsigned Q_AW    = 3;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;
    localparam int unsigned Q_CW    = Q_AW + 1;

    typedef struct packed {
        logic vld_pix;
        logic vld_fl;
        logic col0;
        logic out_mid;
        logic out_last;
        logic top_sel;
        logic x0;
        logic fend;
    } t_s1_ctrl;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] blurred;
    } t_q_entry;

    function automatic logic [VS_W-1:0] f_col_sum(
        input logic [PIX_W-1:0] top,
        input logic [PIX_W-1:0] mid,
        input logic [PIX_W-1:0] bot
    );
        return VS_W'(top) + (VS_W'(mid) << 1) + VS_W'(bot);
    endfunction

    function automatic logic [PIX_W-1:0] f_blur(
        input logic [VS_W-1:0] lft,
        input logic [VS_W-1:0] ctr,
        input logic [VS_W-1:0] rgt
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(lft) + (SUM_W'(ctr) << 1) + SUM_W'(rgt);
        return s[SUM_W-1:4];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gblur_line_mem.sv @@
// ----------------------------------------------------------------------------
// gblur_line_mem
// Row store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_line_mem import gblur_pkg::*; #(
    parameter int unsigned DEPTH = MAX_WIDTH_DEF,
    parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [PIX_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [PIX_W-1:0] o_rdata_a,
    output logic      [PIX_W-1:0] o_rdata_b
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata_a;
    logic [PIX_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

@@ rtl/core/gblur_seq.sv @@
// ----------------------------------------------------------------------------
// gblur_seq
// Configuration registers, column/row/flush counters, store addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_seq import gblur_pkg::*; #(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int unsigned CW        = $clog2(MAX_WIDTH_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tuser,
    input  wire logic [PIX_W-1:0]  i_s_tdata,
    input  wire logic              i_ready,
    output logic                   o_lp_we,
    output logic      [CW-1:0]     o_lp_waddr,
    output logic      [PIX_W-1:0]  o_lp_wdata,
    output logic      [CW-1:0]     o_raddr_a,
    output logic      [CW-1:0]     o_raddr_b,
    output t_s1_ctrl               o_s1,
    output logic      [CW-1:0]     o_s1_col,
    output logic      [PIX_W-1:0]  o_s1_pix
);

    localparam int unsigned LW = ((CW > FW_W) ? CW : FW_W) + 1;

    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [CW-1:0]    r_flush;
    logic [CW-1:0]    n_flush;
    logic [FH_W-1:0]  r_row;
    logic [FH_W-1:0]  n_row;
    t_s1_ctrl         r_s1;
    t_s1_ctrl         n_s1;
    logic [CW-1:0]    r_s1_col;
    logic [PIX_W-1:0] r_s1_pix;

    logic [LW-1:0]   fw_ext;
    logic [LW-1:0]   wl_ext;
    logic [CW-1:0]   w_last;
    logic [FH_W-1:0] h_eff;
    logic            row_full;
    logic            xfer;
    logic            do_pix;
    logic            do_fl;
    logic            col_end;
    logic            fl_end;
    logic [CW-1:0]   flush_r;

    always_comb begin
        fw_ext = LW'(r_fw);
        if (r_fw == '0) begin
            wl_ext = '0;
        end else if (fw_ext > LW'(MAX_WIDTH)) begin
            wl_ext = LW'(MAX_WIDTH - 1);
        end else begin
            wl_ext = fw_ext - LW'(1);
        end
        w_last = wl_ext[CW-1:0];
    end

    assign h_eff    = (r_fh == '0) ? FH_W'(1) : r_fh;
    assign row_full = (r_row >= h_eff);
    assign col_end  = (r_col >= w_last);
    assign fl_end   = (r_flush >= w_last);
    assign flush_r  = fl_end ? r_flush : r_flush + CW'(1);

    assign xfer   = i_s_tvalid & i_ready;
    assign do_pix = xfer & ~row_full & (i_s_tuser == MODE_PIXEL);
    assign do_fl  = xfer & row_full & (i_s_tuser == MODE_FLUSH);

    assign o_raddr_a  = row_full ? r_flush : r_col;
    assign o_raddr_b  = flush_r;
    assign o_lp_we    = do_pix;
    assign o_lp_waddr = r_col;
    assign o_lp_wdata = i_s_tdata;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (do_pix) begin
            if (col_end) begin
                n_col   = '0;
                n_row   = r_row + FH_W'(1);
                n_flush = '0;
            end else begin
                n_col = r_col + CW'(1);
            end
        end else if (do_fl) begin
            if (fl_end) begin
                n_col   = '0;
                n_row   = '0;
                n_flush = '0;
            end else begin
                n_flush = r_flush + CW'(1);
            end
        end
    end

    always_comb begin
        n_s1.vld_pix  = do_pix;
        n_s1.vld_fl   = do_fl;
        n_s1.col0     = (r_col == '0);
        n_s1.out_mid  = (r_row >= FH_W'(1)) && (r_col != '0);
        n_s1.out_last = (r_row >= FH_W'(1)) && col_end;
        n_s1.top_sel  = (r_row >= FH_W'(2));
        n_s1.x0       = (r_flush == '0);
        n_s1.fend     = fl_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= FRAME_WIDTH_RST;
            r_fh    <= FRAME_HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
            r_s1    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_FRAME_WIDTH:  r_fw <= i_cfg_wdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: r_fh <= i_cfg_wdata[FH_W-1:0];
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
            r_s1    <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col <= r_col;
        r_s1_pix <= i_s_tdata;
    end

    assign o_s1     = r_s1;
    assign o_s1_col = r_s1_col;
    assign o_s1_pix = r_s1_pix;

endmodule

`default_nettype wire

@@ rtl/core/gblur_filter.sv @@
// ----------------------------------------------------------------------------
// gblur_filter
// Window of column sums, kernel evaluation, second row store write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_filter import gblur_pkg::*; #(
    parameter int unsigned CW = $clog2(MAX_WIDTH_DEF)
) (
    input  wire logic             i_clk,
    input  wire t_s1_ctrl         i_s1,
    input  wire logic [CW-1:0]    i_s1_col,
    input  wire logic [PIX_W-1:0] i_s1_pix,
    input  wire logic [CW-1:0]    i_raddr_a,
    input  wire logic [CW-1:0]    i_raddr_b,
    input  wire logic [PIX_W-1:0] i_lp_a,
    input  wire logic [PIX_W-1:0] i_lp_b,
    input  wire logic [PIX_W-1:0] i_lp2_a,
    input  wire logic [PIX_W-1:0] i_lp2_b,
    output logic                  o_lp2_we,
    output logic      [CW-1:0]    o_lp2_waddr,
    output logic      [PIX_W-1:0] o_lp2_wdata,
    output logic      [1:0]       o_push_n,
    output t_q_entry              o_push0,
    output t_q_entry              o_push1
);

    logic [VS_W-1:0]  r_vs_c;
    logic [VS_W-1:0]  r_vs_r;
    logic [VS_W-1:0]  r_fvs;
    logic             r_fwd_a;
    logic             r_fwd_b;
    logic [PIX_W-1:0] r_fwd_data;

    logic [PIX_W-1:0] lp2_a;
    logic [PIX_W-1:0] lp2_b;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
    logic [VS_W-1:0]  vs_new;
    logic [VS_W-1:0]  vs_l;
    logic [VS_W-1:0]  vs_c;
    logic [PIX_W-1:0] res_mid;
    logic [PIX_W-1:0] res_last;
    logic [PIX_W-1:0] fc_up;
    logic [PIX_W-1:0] fr_up;
    logic [VS_W-1:0]  fvs_l;
    logic [VS_W-1:0]  fvs_c;
    logic [VS_W-1:0]  fvs_r;
    logic [PIX_W-1:0] res_fl;

    // forward the write-back that lands in the same cycle as the read
    assign lp2_a = r_fwd_a ? r_fwd_data : i_lp2_a;
    assign lp2_b = r_fwd_b ? r_fwd_data : i_lp2_b;

    assign mid    = i_lp_a;
    assign top    = i_s1.top_sel ? lp2_a : mid;
    assign vs_new = f_col_sum(top, mid, i_s1_pix);

    always_comb begin
        if (i_s1.col0) begin
            vs_l = vs_new;
            vs_c = vs_new;
        end else begin
            vs_l = r_vs_c;
            vs_c = r_vs_r;
        end
    end

    assign res_mid  = f_blur(vs_l, vs_c, vs_new);
    assign res_last = f_blur(vs_c, vs_new, vs_new);

    assign fc_up  = i_s1.top_sel ? lp2_a : i_lp_a;
    assign fr_up  = i_s1.top_sel ? lp2_b : i_lp_b;
    assign fvs_c  = f_col_sum(fc_up, i_lp_a, i_lp_a);
    assign fvs_r  = f_col_sum(fr_up, i_lp_b, i_lp_b);
    assign fvs_l  = i_s1.x0 ? fvs_c : r_fvs;
    assign res_fl = f_blur(fvs_l, fvs_c, fvs_r);

    always_comb begin
        o_push_n = 2'd0;
        o_push0  = '{last: 1'b0, blurred: res_mid};
        o_push1  = '{last: 1'b0, blurred: res_last};
        if (i_s1.vld_fl) begin
            o_push_n = 2'd1;
            o_push0  = '{last: i_s1.fend, blurred: res_fl};
        end else if (i_s1.vld_pix) begin
            unique case ({i_s1.out_mid, i_s1.out_last})
                2'b00: o_push_n = 2'd0;
                2'b01: begin
                    o_push_n = 2'd1;
                    o_push0  = '{last: 1'b0, blurred: res_last};
                end
                2'b10: o_push_n = 2'd1;
                2'b11: o_push_n = 2'd2;
            endcase
        end
    end

    assign o_lp2_we    = i_s1.vld_pix;
    assign o_lp2_waddr = i_s1_col;
    assign o_lp2_wdata = mid;

    always_ff @(posedge i_clk) begin
        if (i_s1.vld_pix) begin
            r_vs_c <= vs_c;
            r_vs_r <= vs_new;
        end
        if (i_s1.vld_fl) begin
            r_fvs <= fvs_c;
        end
        r_fwd_a    <= i_s1.vld_pix && (i_s1_col == i_raddr_a);
        r_fwd_b    <= i_s1.vld_pix && (i_s1_col == i_raddr_b);
        r_fwd_data <= mid;
    end

endmodule

`default_nettype wire

@@ rtl/core/gblur_out_fifo.sv @@
// ----------------------------------------------------------------------------
// gblur_out_fifo
// Result queue: up to two pushes per cycle, one pop, input credit check.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_out_fifo import gblur_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push_n,
    input  wire t_q_entry         i_push0,
    input  wire t_q_entry         i_push1,
    output logic                  o_ready,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic      [PIX_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    t_q_entry        r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic            pop;
    logic [Q_AW-1:0] wp1;
    t_q_entry        head;

    assign head       = r_q[r_rp];
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = head.blurred;
    assign o_m_tlast  = head.last;
    assign pop        = o_m_tvalid & i_m_tready;
    assign wp1        = r_wp + Q_AW'(1);

    // leave room for the results of one more item in flight
    assign o_ready = ((Q_CW + 1)'(r_cnt) + (Q_CW + 1)'(i_push_n))
                     <= (Q_CW + 1)'(Q_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push_n);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + Q_CW'(i_push_n) - Q_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[r_wp] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_q[wp1] <= i_push1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/gaussian_blur_3x3_replicate.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_replicate
// Streaming 3x3 binomial blur of an 8-bit grey frame with edge replication.
// ----------------------------------------------------------------------------
// Slave stream takes pixels in raster order (tuser 0) and flush ticks
// (tuser 1); the master stream gives blurred pixels, tlast on the final
// result of a frame. Results lag one row and one pixel behind the input;
// after the last pixel of a frame, one flush tick per column emits the
// last row. Frame size comes from the write port and is to be changed only
// while the block is idle; the block itself does not enforce this.
// Throughput: one item per clock while tready is high. Each item reads
// both row stores at its column in the accepting cycle and is evaluated
// in the next one; its results then pass through the result queue to the
// master side. A pixel that ends a row after the first yields two results
// (one if the frame is one column wide); an eight-entry result queue
// absorbs them, and tready drops only when the queue cannot take the
// results of one more item. Reset clears counters, the pipeline and the
// queue and loads the default size (160 x 31); row stores are not cleared.
// A stalled master side holds its result and backs up into tready.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_replicate import gblur_pkg::*; #(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [PIX_W-1:0]  i_s_tdata,   // [7:0] pixel
    input  wire logic              i_s_tuser,   // [0] mode
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [PIX_W-1:0]  o_m_tdata,   // [7:0] blurred
    output logic                   o_m_tlast
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    logic             lp_we;
    logic [CW-1:0]    lp_waddr;
    logic [PIX_W-1:0] lp_wdata;
    logic [CW-1:0]    raddr_a;
    logic [CW-1:0]    raddr_b;
    t_s1_ctrl         s1;
    logic [CW-1:0]    s1_col;
    logic [PIX_W-1:0] s1_pix;
    logic [PIX_W-1:0] lp_a;
    logic [PIX_W-1:0] lp_b;
    logic [PIX_W-1:0] lp2_a;
    logic [PIX_W-1:0] lp2_b;
    logic             lp2_we;
    logic [CW-1:0]    lp2_waddr;
    logic [PIX_W-1:0] lp2_wdata;
    logic [1:0]       push_n;
    t_q_entry         push0;
    t_q_entry         push1;

    gblur_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_ready     (o_s_tready),
        .o_lp_we     (lp_we),
        .o_lp_waddr  (lp_waddr),
        .o_lp_wdata  (lp_wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_s1        (s1),
        .o_s1_col    (s1_col),
        .o_s1_pix    (s1_pix)
    );

    gblur_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_prev (
        .i_clk     (i_clk),
        .i_we      (lp_we),
        .i_waddr   (lp_waddr),
        .i_wdata   (lp_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (lp_a),
        .o_rdata_b (lp_b)
    );

    gblur_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_prev2 (
        .i_clk     (i_clk),
        .i_we      (lp2_we),
        .i_waddr   (lp2_waddr),
        .i_wdata   (lp2_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (lp2_a),
        .o_rdata_b (lp2_b)
    );

    gblur_filter #(
        .CW (CW)
    ) u_filter (
        .i_clk       (i_clk),
        .i_s1        (s1),
        .i_s1_col    (s1_col),
        .i_s1_pix    (s1_pix),
        .i_raddr_a   (raddr_a),
        .i_raddr_b   (raddr_b),
        .i_lp_a      (lp_a),
        .i_lp_b      (lp_b),
        .i_lp2_a     (lp2_a),
        .i_lp2_b     (lp2_b),
        .o_lp2_we    (lp2_we),
        .o_lp2_waddr (lp2_waddr),
        .o_lp2_wdata (lp2_wdata),
        .o_push_n    (push_n),
        .o_push0     (push0),
        .o_push1     (push1)
    );

    gblur_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push0    (push0),
        .i_push1    (push1),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/gblur_checker.sv @@
// ----------------------------------------------------------------------------
// gblur_checker
// Port-level checks of the blur block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_checker import gblur_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [PIX_W-1:0]  o_m_tdata,
    input wire logic              o_m_tlast
);

    logic in_xfer;

    assign in_xfer = i_s_tvalid & o_s_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(in_xfer) && !o_m_tvalid && !in_xfer
            |=> !o_m_tvalid ##1 !o_m_tvalid)
        else $error("result without a causing transfer");

endmodule

bind gaussian_blur_3x3_replicate gblur_checker u_gblur_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

`default_nettype wire
